// ----- design/tcfos_pkg.sv -----
package tcfos_pkg;

    // Default number of queue entries.
    localparam int unsigned DEFAULT_DEPTH = 16;

    // Fixed field widths.
    localparam int unsigned CMD_W  = 2;
    localparam int unsigned TAG_W  = 8;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned OCC_W  = 5;

    // Entry classes.
    localparam logic KIND_DOG = 1'b0;
    localparam logic KIND_CAT = 1'b1;

    // Command codes carried by an input word.
    typedef enum logic [CMD_W-1:0] {
        CMD_ENQ = 2'd0,
        CMD_ANY = 2'd1,
        CMD_C0  = 2'd2,
        CMD_C1  = 2'd3
    } t_cmd;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // Capture the input word and form the match vector.
        logic commit;  // Update the queue and load the result register.
    } t_dp_ctl;

endpackage

// ----- design/two_class_fifo_oldest_select_core.sv -----
// Arrival-ordered queue of up to DEPTH tagged entries of two classes. A
// command word either appends an entry at the tail or removes the oldest
// entry overall or the oldest entry of one class; younger entries then move
// up one place so arrival order is kept. Every command word gives exactly one
// result word with a status, the removed entry (zero when none) and the
// occupancy after the command, reported as the low five bits of the count.
// A command is accepted, which captures the word and forms the vector of
// matching entries, and then committed: the lowest match is isolated by a single
// DEPTH-bit two's complement add, the queue is updated and the result
// register is loaded. The next word is accepted in the cycle after that
// commit; a result left waiting at the output only holds back the commit
// of the following command.
module two_class_fifo_oldest_select_core #(
    parameter int unsigned DEPTH = tcfos_pkg::DEFAULT_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [tcfos_pkg::CMD_W-1:0]   i_cmd,
    input  logic                          i_kind,
    input  logic [tcfos_pkg::TAG_W-1:0]   i_tag,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [tcfos_pkg::STAT_W-1:0]  o_status,
    output logic                          o_out_kind,
    output logic [tcfos_pkg::TAG_W-1:0]   o_out_tag,
    output logic [tcfos_pkg::OCC_W-1:0]   o_occupancy
);
    import tcfos_pkg::*;

    t_dp_ctl dp_ctl;

    // Sequencing of accept, commit and result handshake.
    tcfos_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_ctl       (dp_ctl)
    );

    // Queue storage, match logic and result register.
    tcfos_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (dp_ctl),
        .i_cmd       (i_cmd),
        .i_kind      (i_kind),
        .i_tag       (i_tag),
        .o_status    (o_status),
        .o_out_kind  (o_out_kind),
        .o_out_tag   (o_out_tag),
        .o_occupancy (o_occupancy)
    );

endmodule

// ----- design/tcfos_ctrl.sv -----
module tcfos_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tcfos_pkg::t_dp_ctl  o_ctl
);
    import tcfos_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_COMMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    // The result register can take a new word when empty or being drained.
    assign out_free = !r_out_valid || i_out_ready;

    // Datapath commands.
    always_comb begin
        o_ctl.load   = (r_state == S_IDLE) && i_in_valid;
        o_ctl.commit = (r_state == S_COMMIT) && out_free;
    end

    // Next state and next result valid.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ----- design/tcfos_dpath.sv -----
module tcfos_dpath #(
    parameter int unsigned DEPTH = tcfos_pkg::DEFAULT_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tcfos_pkg::t_dp_ctl                i_ctl,
    input  logic [tcfos_pkg::CMD_W-1:0]       i_cmd,
    input  logic                              i_kind,
    input  logic [tcfos_pkg::TAG_W-1:0]       i_tag,
    output logic [tcfos_pkg::STAT_W-1:0]      o_status,
    output logic                              o_out_kind,
    output logic [tcfos_pkg::TAG_W-1:0]       o_out_tag,
    output logic [tcfos_pkg::OCC_W-1:0]       o_occupancy
);
    import tcfos_pkg::*;

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    // Captured command word.
    t_cmd               r_op;
    logic               r_kind;
    logic [TAG_W-1:0]   r_tag;
    logic [DEPTH-1:0]   r_mask;
    logic [DEPTH-1:0]   n_mask;
    logic [DEPTH-1:0]   class_sel;

    // Queue storage; position 0 holds the oldest entry.
    logic [DEPTH-1:0]   r_class;
    logic [TAG_W-1:0]   r_tags [DEPTH];
    logic [DEPTH-1:0]   r_occ;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;

    // Commit-cycle decode.
    logic [DEPTH-1:0]   neg_mask;
    logic [DEPTH-1:0]   first_hit;
    logic [DEPTH-1:0]   shift_en;
    logic [DEPTH-1:0]   tail_sel;
    logic               found;
    logic               is_enq;
    logic               full;
    logic               do_push;
    logic               do_pop;
    logic               rm_kind;
    logic [TAG_W-1:0]   rm_tag;
    logic [CNT_W+OCC_W-1:0] occ_wide;

    // Result register.
    t_status            r_status;
    logic               r_out_kind;
    logic [TAG_W-1:0]   r_out_tag;
    logic [OCC_W-1:0]   r_occupancy;

    // Select the entries that the incoming command may remove.
    always_comb begin
        case (t_cmd'(i_cmd))
            CMD_ANY: class_sel = '1;
            CMD_C0:  class_sel = ~r_class;
            CMD_C1:  class_sel = r_class;
            default: class_sel = '0;
        endcase
        n_mask = r_occ & class_sel;
    end

    // Capture the command word and its match vector on acceptance.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_op   <= t_cmd'(i_cmd);
            r_kind <= i_kind;
            r_tag  <= i_tag;
            r_mask <= n_mask;
        end
    end

    // The lowest set bit of the match vector is the oldest match. Two's
    // complement isolates it, and its OR with the mask marks every place
    // from the match upwards, which is the region that moves up one place.
    assign neg_mask  = (~r_mask) + {{(DEPTH-1){1'b0}}, 1'b1};
    assign first_hit = r_mask & neg_mask;
    assign shift_en  = r_mask | neg_mask;
    assign found     = |r_mask;

    assign is_enq   = (r_op == CMD_ENQ);
    assign full     = r_occ[DEPTH-1];
    assign do_push  = is_enq && !full;
    assign do_pop   = !is_enq && found;
    assign tail_sel = {r_occ[DEPTH-2:0], 1'b1} & ~r_occ;

    // Read out the removed entry through its one-hot select.
    always_comb begin
        rm_kind = |(first_hit & r_class);
        rm_tag  = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (first_hit[i]) begin
                rm_tag = rm_tag | r_tags[i];
            end
        end
    end

    // Entry update: append at the tail, or close the gap left by a removal.
    for (genvar g = 0; g < DEPTH; g++) begin : g_entry
        if (g < DEPTH - 1) begin : g_mid
            always_ff @(posedge i_clk) begin
                if (i_ctl.commit) begin
                    if (do_push && tail_sel[g]) begin
                        r_class[g] <= r_kind;
                        r_tags[g]  <= r_tag;
                    end else if (do_pop && shift_en[g]) begin
                        r_class[g] <= r_class[g+1];
                        r_tags[g]  <= r_tags[g+1];
                    end
                end
            end
        end else begin : g_last
            always_ff @(posedge i_clk) begin
                if (i_ctl.commit && do_push && tail_sel[g]) begin
                    r_class[g] <= r_kind;
                    r_tags[g]  <= r_tag;
                end
            end
        end
    end

    // Next fill count.
    always_comb begin
        n_count = r_count;
        if (do_push) begin
            n_count = r_count + {{(CNT_W-1){1'b0}}, 1'b1};
        end else if (do_pop) begin
            n_count = r_count - {{(CNT_W-1){1'b0}}, 1'b1};
        end
    end

    assign occ_wide = {{OCC_W{1'b0}}, n_count};

    // Fill count and the thermometer of held places.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_occ   <= '0;
        end else if (i_ctl.commit) begin
            r_count <= n_count;
            if (do_push) begin
                r_occ <= {r_occ[DEPTH-2:0], 1'b1};
            end else if (do_pop) begin
                r_occ <= {1'b0, r_occ[DEPTH-1:1]};
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_ctl.commit) begin
            if (is_enq) begin
                r_status <= full ? ST_FULL : ST_OK;
            end else begin
                r_status <= found ? ST_OK : ST_EMPTY;
            end
            r_out_kind  <= do_pop ? rm_kind : KIND_DOG;
            r_out_tag   <= do_pop ? rm_tag : '0;
            r_occupancy <= occ_wide[OCC_W-1:0];
        end
    end

    assign o_status    = r_status;
    assign o_out_kind  = r_out_kind;
    assign o_out_tag   = r_out_tag;
    assign o_occupancy = r_occupancy;

endmodule
